[rtl/assert_macros.svh]
// assertion helpers, clocked on clock and quiet while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on the same edge as the trigger
`define CHK_NOW(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("assertion failed: same-cycle check");

// condition holds on the edge after the trigger
`define CHK_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("assertion failed: next-cycle check");

`endif

[rtl/cbtc_pkg.sv]
package cbtc_pkg;

   // field widths
   localparam int CLOCK_W = 32;
   localparam int RATE_W  = 20;
   localparam int PRE_W   = 30;
   localparam int SEG1_W  = 4;
   localparam int SEG2_W  = 3;
   localparam int QPB_W   = 5;

   // quanta search range
   localparam logic [QPB_W-1:0] MAX_QUANTA = 5'd25;
   localparam logic [QPB_W-1:0] MIN_QUANTA = 5'd4;

   localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd8000000;

   // serial divider: one quotient bit per cycle
   localparam int DIV_STEPS = CLOCK_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   typedef struct packed {
      logic               start;
      logic [CLOCK_W-1:0] dividend;
      logic [RATE_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [CLOCK_W-1:0] quotient;
      logic [RATE_W-1:0]  remainder;
   } div_rsp_type;

   // (n - 3) / 3 for n in 3..25, by multiply with 11/32
   function automatic logic [SEG2_W-1:0] seg2_of(input logic [QPB_W-1:0] n);
      logic [QPB_W-1:0] x;
      logic [8:0]       prod;
      x    = n - 5'd3;
      prod = 9'(x) * 9'd11;
      return prod[7:5];
   endfunction

   // (n - 3) - seg2
   function automatic logic [SEG1_W-1:0] seg1_of(input logic [QPB_W-1:0] n);
      logic [QPB_W-1:0] x;
      x = n - 5'd3;
      return x[SEG1_W-1:0] - SEG1_W'(seg2_of(n));
   endfunction

endpackage

[rtl/cbtc_if.sv]
// request channel: one bit rate per word
interface cbtc_req_if;
   logic                       valid;
   logic                       ready;
   logic [cbtc_pkg::RATE_W-1:0] bit_rate;

   modport source (output valid, output bit_rate, input ready);
   modport sink   (input valid, input bit_rate, output ready);
endinterface

// response channel: timing result
interface cbtc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cbtc_pkg::PRE_W-1:0]  prescaler_minus_one;
   logic [cbtc_pkg::SEG1_W-1:0] phase_seg1;
   logic [cbtc_pkg::SEG2_W-1:0] phase_seg2;
   logic [cbtc_pkg::QPB_W-1:0]  quanta_per_bit;
   logic                        error_flag;

   modport source (output valid, output prescaler_minus_one, output phase_seg1,
                   output phase_seg2, output quanta_per_bit, output error_flag,
                   input ready);
   modport sink   (input valid, input prescaler_minus_one, input phase_seg1,
                   input phase_seg2, input quanta_per_bit, input error_flag,
                   output ready);
endinterface

// register write channel: module clock in hertz
interface cbtc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [cbtc_pkg::CLOCK_W-1:0] clock_hz;

   modport source (output valid, output clock_hz, input ready);
   modport sink   (input valid, input clock_hz, output ready);
endinterface

[rtl/cbtc_div.sv]
`include "assert_macros.svh"

module cbtc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cbtc_pkg::div_cmd_type cmd,
   output cbtc_pkg::div_rsp_type rsp
);
   import cbtc_pkg::*;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CLOCK_W-1:0] dvd_ff, dvd_in;
   logic [RATE_W-1:0]  dsr_ff, dsr_in;
   logic [RATE_W-1:0]  rem_ff, rem_in;
   logic               done_ff, done_in;
   logic [RATE_W+1:0]  diff;
   logic               fits;

   // one restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      diff = {1'b0, rem_ff, dvd_ff[CLOCK_W-1]} - {2'b00, dsr_ff};
      fits = ~diff[RATE_W+1];
   end

   always_comb begin
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         count_in = CNT_W'(DIV_STEPS);
         dvd_in   = cmd.dividend;
         dsr_in   = cmd.divisor;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         dvd_in   = {dvd_ff[CLOCK_W-2:0], fits};
         rem_in   = fits ? diff[RATE_W-1:0] : {rem_ff[RATE_W-2:0], dvd_ff[CLOCK_W-1]};
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;

   `CHK_NOW(div_start_when_free, cmd.start, count_ff == '0)
   `CHK_NEXT(div_done_after_last, count_ff == CNT_W'(1) && !cmd.start, done_ff)

endmodule

[rtl/can_bit_timing_calculator_top.sv]
// channel   port      dir  word
// request   req_bus   in   bit_rate
// response  rsp_bus   out  prescaler_minus_one, phase_seg1, phase_seg2,
//                          quanta_per_bit, error_flag
// register  csr_bus   in   clock_hz (always ready)
//
// one request at a time; each serial division yields one quotient bit a cycle
// clock / rate, then up to 22 trial divisions by 25 down to 4
// an exact divisor ends the search early; a zero clock or rate skips the divider and flags an error
// the response register holds a finished word while the next request is taken
// a second finished word waits in the last state until the response register drains
// reset is synchronous; clock_hz returns to 8000000
`include "assert_macros.svh"

module can_bit_timing_calculator_top (
   input logic      clock,
   input logic      reset,
   cbtc_req_if.sink   req_bus,
   cbtc_rsp_if.source rsp_bus,
   cbtc_csr_if.sink   csr_bus
);
   import cbtc_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_QUOT = 2'd1;
   localparam logic [1:0] S_MOD  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CLOCK_W-1:0] clock_ff;
   logic [CLOCK_W-1:0] quot_ff, quot_in;
   logic [QPB_W-1:0]   n_ff, n_in;
   logic [QPB_W-1:0]   chosen_ff, chosen_in;
   logic [CLOCK_W-1:0] pre_ff, pre_in;
   logic [RATE_W-1:0]  best_ff, best_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PRE_W-1:0]   rsp_pre_ff;
   logic [SEG1_W-1:0]  rsp_seg1_ff;
   logic [SEG2_W-1:0]  rsp_seg2_ff;
   logic [QPB_W-1:0]   rsp_qpb_ff;
   logic               rsp_err_ff;
   logic               load_out;
   logic               out_err;

   logic               req_fire;
   logic               out_free;
   logic [QPB_W-1:0]   rem;
   div_cmd_type        div_cmd;
   div_rsp_type        div_rsp;

   cbtc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign out_free      = ~rsp_valid_ff | rsp_bus.ready;
   assign rem           = div_rsp.remainder[QPB_W-1:0];
   assign csr_bus.ready = 1'b1;

   // clock register
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= CLOCK_RESET;
      end else if (csr_bus.valid) begin
         clock_ff <= csr_bus.clock_hz;
      end
   end

   // sequencer: divide, then walk the quanta counts downward
   always_comb begin
      state_in          = state_ff;
      quot_in           = quot_ff;
      n_in              = n_ff;
      chosen_in         = chosen_ff;
      pre_in            = pre_ff;
      best_in           = best_ff;
      load_out          = 1'b0;
      div_cmd.start     = 1'b0;
      div_cmd.dividend  = clock_ff;
      div_cmd.divisor   = req_bus.bit_rate;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               chosen_in = '0;
               best_in   = req_bus.bit_rate;
               if (req_bus.bit_rate == '0 || clock_ff == '0) begin
                  state_in = S_FIN;
               end else begin
                  div_cmd.start = 1'b1;
                  state_in      = S_QUOT;
               end
            end
         end
         S_QUOT: begin
            if (div_rsp.done) begin
               quot_in          = div_rsp.quotient;
               n_in             = MAX_QUANTA;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = div_rsp.quotient;
               div_cmd.divisor  = RATE_W'(MAX_QUANTA);
               state_in         = S_MOD;
            end
         end
         S_MOD: begin
            if (div_rsp.done) begin
               // exact fit or a strictly smaller remainder wins
               if (RATE_W'(rem) < best_ff) begin
                  best_in   = RATE_W'(rem);
                  chosen_in = n_ff;
                  pre_in    = div_rsp.quotient;
               end
               if (rem == '0 || n_ff == MIN_QUANTA) begin
                  state_in = S_FIN;
               end else begin
                  n_in             = n_ff - QPB_W'(1);
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = quot_ff;
                  div_cmd.divisor  = RATE_W'(n_ff - QPB_W'(1));
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff   <= quot_in;
      n_ff      <= n_in;
      chosen_ff <= chosen_in;
      pre_ff    <= pre_in;
      best_ff   <= best_in;
   end

   // response register
   assign out_err = (chosen_ff == '0) || (pre_ff == '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_err_ff <= out_err;
         if (out_err) begin
            rsp_pre_ff  <= '0;
            rsp_seg1_ff <= '0;
            rsp_seg2_ff <= '0;
            rsp_qpb_ff  <= '0;
         end else begin
            rsp_pre_ff  <= PRE_W'(pre_ff - CLOCK_W'(1));
            rsp_seg1_ff <= seg1_of(chosen_ff);
            rsp_seg2_ff <= seg2_of(chosen_ff);
            rsp_qpb_ff  <= chosen_ff;
         end
      end
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.prescaler_minus_one = rsp_pre_ff;
   assign rsp_bus.phase_seg1          = rsp_seg1_ff;
   assign rsp_bus.phase_seg2          = rsp_seg2_ff;
   assign rsp_bus.quanta_per_bit      = rsp_qpb_ff;
   assign rsp_bus.error_flag          = rsp_err_ff;

   `CHK_NEXT(top_busy_after_accept, req_fire, state_ff != S_IDLE)
   `CHK_NOW(top_div_done_in_search, div_rsp.done, state_ff == S_QUOT || state_ff == S_MOD)
   `CHK_NOW(top_err_clears_fields, rsp_valid_ff && rsp_err_ff, rsp_qpb_ff == '0 && rsp_pre_ff == '0)
   `CHK_NOW(top_qpb_in_range, rsp_valid_ff && !rsp_err_ff, rsp_qpb_ff >= MIN_QUANTA && rsp_qpb_ff <= MAX_QUANTA)

endmodule
